// ----- rtl/pidf_pkg.sv -----
package pidf_pkg;

   // Filter weights in Q0.16; they sum to exactly one.
   localparam logic signed [17:0] W_NEW = 18'sd13107;
   localparam logic signed [17:0] W_OLD = 18'sd52429;

   // Widths of the datapath.
   localparam int unsigned MUL_A_W = 18;
   localparam int unsigned MUL_B_W = 34;
   localparam int unsigned PROD_W  = 50;
   localparam int unsigned ACC_W   = 44;
   localparam int unsigned ISUM_W  = 43;
   localparam int unsigned ERR_W   = 33;
   localparam int unsigned DELTA_W = 34;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_GAIN_PROP     = 3'd0,
      REG_GAIN_INTEG    = 3'd1,
      REG_GAIN_DERIV    = 3'd2,
      REG_SETPOINT      = 3'd3,
      REG_INTEG_FLOOR   = 3'd4,
      REG_INTEG_CEILING = 3'd5,
      REG_DRIVE_FLOOR   = 3'd6,
      REG_DRIVE_CEILING = 3'd7
   } reg_index_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILT_NEW,
      ST_FILT_OLD,
      ST_SMOOTH,
      ST_ERROR,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_CLAMP_I,
      ST_SUM,
      ST_CLAMP_D,
      ST_OUTPUT
   } state_type;

endpackage

// ----- rtl/pid_controller_filtered_input.sv -----
// A request is accepted only in the idle state and then sequenced through the filter,
// error, multiply, clamp, sum and output states on the single shared 18x34 multiplier,
// which runs five times per request; a result still held stalls the output state.
// The configuration port is always ready and writes take effect at once.
// Synchronous active-high reset clears the filter, integral and previous error to zero
// and loads the gains, setpoint and limits with their reset values.
module pid_controller_filtered_input
   import pidf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_drive,
   output logic               rsp_drive_clamped,
   output logic               rsp_integ_clamped,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic signed [15:0] csr_wdata
);

   state_type state_ff, state_in;

   // Configuration registers.
   logic signed [15:0] gain_prop_ff, gain_integ_ff, gain_deriv_ff, setpoint_ff;
   logic signed [15:0] integ_floor_ff, integ_ceiling_ff, drive_floor_ff, drive_ceiling_ff;

   // Controller state.
   logic signed [31:0]      smooth_ff, smooth_in;
   logic signed [ERR_W-1:0] prev_err_ff, prev_err_in;
   logic signed [31:0]      integ_ff, integ_in;

   // Working registers.
   logic signed [15:0]        sample_ff, sample_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ISUM_W-1:0]  isum_ff, isum_in;
   logic                      ihit_ff, ihit_in;
   logic                      dhit_ff, dhit_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]        drive_ff, drive_in;
   logic                      dflag_ff, dflag_in;
   logic                      iflag_ff, iflag_in;

   // Shared multiplier operands.
   logic signed [MUL_A_W-1:0]         mul_a;
   logic signed [MUL_B_W-1:0]         mul_b;
   logic signed [MUL_A_W+MUL_B_W-1:0] mul_full;

   // Limits scaled to Q16.16.
   logic signed [ISUM_W-1:0] integ_hi, integ_lo;
   logic signed [ACC_W-1:0]  drive_hi, drive_lo;
   logic signed [31:0]       drive_q;
   logic signed [32:0]       drive_round;

   assign mul_full = mul_a * mul_b;

   assign integ_hi = ISUM_W'(signed'({integ_ceiling_ff, 16'h0000}));
   assign integ_lo = ISUM_W'(signed'({integ_floor_ff, 16'h0000}));
   assign drive_hi = ACC_W'(signed'({drive_ceiling_ff, 16'h0000}));
   assign drive_lo = ACC_W'(signed'({drive_floor_ff, 16'h0000}));

   // Truncation toward zero: bias negative values by one LSB short of a whole unit.
   assign drive_q     = acc_ff[31:0];
   assign drive_round = 33'(drive_q) + ((drive_q < 0) ? 33'sh0FFFF : 33'sh00000);

   assign req_ready         = (state_ff == ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive         = drive_ff;
   assign rsp_drive_clamped = dflag_ff;
   assign rsp_integ_clamped = iflag_ff;

   // Sequencer: next state, multiplier operands and datapath updates.
   always_comb begin
      state_in     = state_ff;
      smooth_in    = smooth_ff;
      prev_err_in  = prev_err_ff;
      integ_in     = integ_ff;
      sample_in    = sample_ff;
      err_in       = err_ff;
      delta_in     = delta_ff;
      acc_in       = acc_ff;
      isum_in      = isum_ff;
      ihit_in      = ihit_ff;
      dhit_in      = dhit_ff;
      drive_in     = drive_ff;
      dflag_in     = dflag_ff;
      iflag_in     = iflag_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      mul_a        = '0;
      mul_b        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               state_in  = ST_FILT_NEW;
            end
         end
         ST_FILT_NEW: begin
            mul_a    = W_NEW;
            mul_b    = MUL_B_W'(sample_ff);
            state_in = ST_FILT_OLD;
         end
         ST_FILT_OLD: begin
            mul_a    = W_OLD;
            mul_b    = MUL_B_W'(smooth_ff);
            acc_in   = ACC_W'(prod_ff);
            state_in = ST_SMOOTH;
         end
         ST_SMOOTH: begin
            smooth_in = 32'(acc_ff + ACC_W'(prod_ff >>> 16));
            state_in  = ST_ERROR;
         end
         ST_ERROR: begin
            err_in   = ERR_W'(signed'({setpoint_ff, 16'h0000})) - ERR_W'(smooth_ff);
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            mul_a    = MUL_A_W'(gain_prop_ff);
            mul_b    = MUL_B_W'(err_ff);
            delta_in = DELTA_W'(err_ff) - DELTA_W'(prev_err_ff);
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            mul_a    = MUL_A_W'(gain_integ_ff);
            mul_b    = MUL_B_W'(err_ff);
            acc_in   = ACC_W'(prod_ff >>> 8);
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            mul_a    = MUL_A_W'(gain_deriv_ff);
            mul_b    = delta_ff;
            isum_in  = ISUM_W'(integ_ff) + ISUM_W'(prod_ff >>> 8);
            state_in = ST_CLAMP_I;
         end
         ST_CLAMP_I: begin
            // Ceiling is tested before floor.
            if (isum_ff > integ_hi) begin
               integ_in = 32'(integ_hi);
               ihit_in  = 1'b1;
            end else if (isum_ff < integ_lo) begin
               integ_in = 32'(integ_lo);
               ihit_in  = 1'b1;
            end else begin
               integ_in = 32'(isum_ff);
               ihit_in  = 1'b0;
            end
            acc_in      = acc_ff + ACC_W'(prod_ff >>> 8);
            prev_err_in = err_ff;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            acc_in   = acc_ff + ACC_W'(integ_ff);
            state_in = ST_CLAMP_D;
         end
         ST_CLAMP_D: begin
            if (acc_ff > drive_hi) begin
               acc_in  = drive_hi;
               dhit_in = 1'b1;
            end else if (acc_ff < drive_lo) begin
               acc_in  = drive_lo;
               dhit_in = 1'b1;
            end else begin
               dhit_in = 1'b0;
            end
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            // Wait here while an earlier result is still held.
            if (!rsp_valid_ff || rsp_ready) begin
               drive_in     = drive_round[31:16];
               dflag_in     = dhit_ff;
               iflag_in     = ihit_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      prod_in = mul_full[PROD_W-1:0];
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         smooth_ff        <= '0;
         prev_err_ff      <= '0;
         integ_ff         <= '0;
         gain_prop_ff     <= '0;
         gain_integ_ff    <= '0;
         gain_deriv_ff    <= '0;
         setpoint_ff      <= '0;
         integ_floor_ff   <= 16'sh8000;
         integ_ceiling_ff <= 16'sh7FFF;
         drive_floor_ff   <= 16'sh8000;
         drive_ceiling_ff <= 16'sh7FFF;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         smooth_ff    <= smooth_in;
         prev_err_ff  <= prev_err_in;
         integ_ff     <= integ_in;
         if (csr_valid) begin
            unique case (reg_index_type'(csr_index))
               REG_GAIN_PROP:     gain_prop_ff     <= csr_wdata;
               REG_GAIN_INTEG:    gain_integ_ff    <= csr_wdata;
               REG_GAIN_DERIV:    gain_deriv_ff    <= csr_wdata;
               REG_SETPOINT:      setpoint_ff      <= csr_wdata;
               REG_INTEG_FLOOR:   integ_floor_ff   <= csr_wdata;
               REG_INTEG_CEILING: integ_ceiling_ff <= csr_wdata;
               REG_DRIVE_FLOOR:   drive_floor_ff   <= csr_wdata;
               REG_DRIVE_CEILING: drive_ceiling_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      err_ff    <= err_in;
      delta_ff  <= delta_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      isum_ff   <= isum_in;
      ihit_ff   <= ihit_in;
      dhit_ff   <= dhit_in;
      drive_ff  <= drive_in;
      dflag_ff  <= dflag_in;
      iflag_ff  <= iflag_in;
   end

endmodule

// ----- rtl/pidf_checker.sv -----
module pidf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_drive,
   input logic        rsp_drive_clamped,
   input logic        rsp_integ_clamped
);

   // A held result keeps its valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   // A held result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_drive) && $stable(rsp_drive_clamped)
                                  && $stable(rsp_integ_clamped))
      else $error("result payload changed while held");

   // An accepted request makes the block busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a request is in work");

   // A new result appears only at the end of a busy period.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a request in work");

endmodule

bind pid_controller_filtered_input pidf_checker u_pidf_checker (.*);

// ----- tb/tb_pid_controller_filtered_input.sv -----
`timescale 1ns / 1ps

module tb_pid_controller_filtered_input
   import pidf_pkg::*;
();

   // Filter weights in Q0.16 and the scale of one sample unit in Q16.16.
   localparam longint FILT_NEW  = 13107;
   localparam longint FILT_OLD  = 52429;
   localparam longint UNIT_Q16  = 65536;
   localparam int     MAX_CYCLES = 600000;
   localparam int     TAIL_CYCLES = 24;

   typedef struct {
      logic signed [15:0] drive;
      logic               drive_clamped;
      logic               integ_clamped;
   } drive_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_sample;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_drive;
   logic               rsp_drive_clamped;
   logic               rsp_integ_clamped;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic signed [15:0] csr_wdata;

   // Controller settings as the testbench believes them to be.
   logic signed [15:0] gain_p, gain_i, gain_d, target;
   logic signed [15:0] integ_lo, integ_hi, drive_lo, drive_hi;

   // Controller state in Q16.16.
   longint             filt_q, integ_q, prev_err_q;

   drive_result_type   pending_drives[$];

   int                 errors;
   int                 requests_sent;
   int                 results_checked;
   int                 reg_writes;
   int                 integ_clamps_seen;
   int                 drive_clamps_seen;
   int                 cycle_count;
   int                 send_idle_pct;
   int                 stall_pct;
   int                 hold_left;

   pid_controller_filtered_input u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive         (rsp_drive),
      .rsp_drive_clamped (rsp_drive_clamped),
      .rsp_integ_clamped (rsp_integ_clamped),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit, reckoned from the slowest correct run with a wide margin.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending_drives.size());
         $display("pid_controller_filtered_input test failed");
         $finish;
      end
   end

   // Result side ready: a long hold-off when one is asked for, else random stalls.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready = ($urandom_range(99, 0) >= stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch in %s at result %0d: got %0d, expected %0d",
               what, results_checked, got, want);
      errors = errors + 1;
   endtask

   // Each accepted result is compared with the oldest expected one.
   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_drives.size() == 0) begin
            report_mismatch("unexpected result drive", rsp_drive, 0);
         end else begin
            want = pending_drives.pop_front();
            if (rsp_drive !== want.drive)
               report_mismatch("drive", rsp_drive, want.drive);
            if (rsp_drive_clamped !== want.drive_clamped)
               report_mismatch("drive_clamped", rsp_drive_clamped, want.drive_clamped);
            if (rsp_integ_clamped !== want.integ_clamped)
               report_mismatch("integ_clamped", rsp_integ_clamped, want.integ_clamped);
         end
         results_checked = results_checked + 1;
      end
   end

   // Works out the drive for one accepted sample and advances the controller state.
   function automatic drive_result_type compute_drive(input logic signed [15:0] smp);
      drive_result_type res;
      longint           err, p_term, i_term, d_term, total;
      filt_q = (FILT_NEW * (longint'(smp) * UNIT_Q16) + FILT_OLD * filt_q) >>> 16;
      err    = longint'(target) * UNIT_Q16 - filt_q;
      p_term = (longint'(gain_p) * err) >>> 8;
      i_term = integ_q + ((longint'(gain_i) * err) >>> 8);
      d_term = (longint'(gain_d) * (err - prev_err_q)) >>> 8;

      // The ceiling is tested first, so inverted limits favor it.
      res.integ_clamped = 1'b1;
      if (i_term > longint'(integ_hi) * UNIT_Q16)
         i_term = longint'(integ_hi) * UNIT_Q16;
      else if (i_term < longint'(integ_lo) * UNIT_Q16)
         i_term = longint'(integ_lo) * UNIT_Q16;
      else
         res.integ_clamped = 1'b0;
      integ_q    = i_term;
      prev_err_q = err;

      total = p_term + i_term + d_term;
      res.drive_clamped = 1'b1;
      if (total > longint'(drive_hi) * UNIT_Q16)
         total = longint'(drive_hi) * UNIT_Q16;
      else if (total < longint'(drive_lo) * UNIT_Q16)
         total = longint'(drive_lo) * UNIT_Q16;
      else
         res.drive_clamped = 1'b0;

      // Signed division truncates the fraction toward zero.
      res.drive = 16'(total / UNIT_Q16);
      return res;
   endfunction

   // Offers one request, idling first at the current rate, and records its expected result.
   task automatic send_sample(input logic signed [15:0] smp);
      drive_result_type want;
      @(negedge clock);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid = 1'b0;
         req_sample = 16'($urandom);
         @(negedge clock);
      end
      req_valid  = 1'b1;
      req_sample = smp;
      do @(posedge clock); while (!req_ready);
      want = compute_drive(smp);
      pending_drives.push_back(want);
      requests_sent = requests_sent + 1;
      if (want.integ_clamped) integ_clamps_seen = integ_clamps_seen + 1;
      if (want.drive_clamped) drive_clamps_seen = drive_clamps_seen + 1;
   endtask

   // Stops offering requests and waits until every expected result has come.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
   endtask

   // Writes one register; only called while the controller is idle.
   task automatic write_reg(input reg_index_type idx, input logic signed [15:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_GAIN_PROP:     gain_p   = value;
         REG_GAIN_INTEG:    gain_i   = value;
         REG_GAIN_DERIV:    gain_d   = value;
         REG_SETPOINT:      target   = value;
         REG_INTEG_FLOOR:   integ_lo = value;
         REG_INTEG_CEILING: integ_hi = value;
         REG_DRIVE_FLOOR:   drive_lo = value;
         REG_DRIVE_CEILING: drive_hi = value;
         default: ;
      endcase
      reg_writes = reg_writes + 1;
      @(negedge clock);
      csr_valid = 1'b0;
      csr_wdata = 16'($urandom);
   endtask

   // Gains: moderate so that outputs vary, full range, extreme, or 256 or zero, in equal shares.
   function automatic logic signed [15:0] pick_gain();
      case ($urandom_range(3, 0))
         0: return 16'($urandom_range(1023, 0)) - 16'sd512;
         1: return 16'($urandom);
         2: return $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
         default: return $urandom_range(1, 0) ? 16'sd256 : 16'sd0;
      endcase
   endfunction

   // Limit pairs: ordered, full range, or inverted.
   task automatic pick_limits(output logic signed [15:0] lo, output logic signed [15:0] hi);
      logic signed [15:0] a, b;
      a = 16'($urandom);
      b = 16'($urandom);
      case ($urandom_range(9, 0))
         0, 1: begin
            lo = 16'sh8000;
            hi = 16'sh7FFF;
         end
         2: begin
            lo = (a > b) ? a : b;
            hi = (a > b) ? b : a;
         end
         default: begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
         end
      endcase
   endtask

   task automatic randomize_config();
      logic signed [15:0] lo, hi;
      write_reg(REG_GAIN_PROP, pick_gain());
      write_reg(REG_GAIN_INTEG, pick_gain());
      write_reg(REG_GAIN_DERIV, pick_gain());
      write_reg(REG_SETPOINT, $urandom_range(1, 0) ? 16'($urandom)
                                                     : 16'($urandom_range(2000, 0)) - 16'sd1000);
      pick_limits(lo, hi);
      write_reg(REG_INTEG_FLOOR, lo);
      write_reg(REG_INTEG_CEILING, hi);
      pick_limits(lo, hi);
      write_reg(REG_DRIVE_FLOOR, lo);
      write_reg(REG_DRIVE_CEILING, hi);
   endtask

   // With the gains at reset the drive stays at zero whatever the sample.
   task automatic test_reset_state();
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      wait_for_drain();
   endtask

   // Sample and gain extremes, first with unit gain, then with full-scale gains.
   task automatic test_field_extremes();
      write_reg(REG_GAIN_PROP, 16'sd256);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sd0);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      wait_for_drain();
      write_reg(REG_GAIN_PROP, 16'sh8000);
      write_reg(REG_GAIN_INTEG, 16'sh7FFF);
      write_reg(REG_GAIN_DERIV, 16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      wait_for_drain();
   endtask

   // The integral is driven into each limit, then held exactly on it with the
   // integral gain at zero; a value equal to a limit must not count as clamped.
   task automatic test_exact_limits();
      write_reg(REG_GAIN_PROP, 16'sd0);
      write_reg(REG_GAIN_DERIV, 16'sd0);
      write_reg(REG_GAIN_INTEG, 16'sd256);
      write_reg(REG_SETPOINT, 16'sd1000);
      write_reg(REG_INTEG_FLOOR, -16'sd50);
      write_reg(REG_INTEG_CEILING, 16'sd50);
      send_sample(16'sd0);
      send_sample(16'sd0);
      wait_for_drain();
      write_reg(REG_GAIN_INTEG, 16'sd0);
      write_reg(REG_DRIVE_CEILING, 16'sd50);
      send_sample(16'sd0);
      wait_for_drain();
      write_reg(REG_GAIN_INTEG, 16'sd256);
      write_reg(REG_SETPOINT, -16'sd1000);
      send_sample(16'sd0);
      send_sample(16'sd0);
      wait_for_drain();
      write_reg(REG_GAIN_INTEG, 16'sd0);
      write_reg(REG_DRIVE_FLOOR, -16'sd50);
      send_sample(16'sd0);
      wait_for_drain();
   endtask

   // Floors above ceilings: the ceiling is still tested first.
   task automatic test_inverted_limits();
      write_reg(REG_GAIN_PROP, 16'sd256);
      write_reg(REG_GAIN_INTEG, 16'sd256);
      write_reg(REG_SETPOINT, 16'sd0);
      write_reg(REG_INTEG_FLOOR, 16'sd100);
      write_reg(REG_INTEG_CEILING, -16'sd100);
      write_reg(REG_DRIVE_FLOOR, 16'sd200);
      write_reg(REG_DRIVE_CEILING, -16'sd200);
      send_sample(16'sd20000);
      send_sample(-16'sd20000);
      send_sample(16'sd0);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      wait_for_drain();
      write_reg(REG_INTEG_FLOOR, 16'sh8000);
      write_reg(REG_INTEG_CEILING, 16'sh7FFF);
      write_reg(REG_DRIVE_FLOOR, 16'sh8000);
      write_reg(REG_DRIVE_CEILING, 16'sh7FFF);
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the controller fills up and stops accepting.
   task automatic test_result_backpressure();
      int k;
      send_idle_pct = 0;
      stall_pct = 0;
      write_reg(REG_GAIN_PROP, 16'sd300);
      write_reg(REG_GAIN_INTEG, 16'sd20);
      write_reg(REG_GAIN_DERIV, -16'sd100);
      write_reg(REG_SETPOINT, 16'sd500);
      hold_left = 300;
      for (k = 0; k < 10; k++)
         send_sample(16'($urandom));
      wait_for_drain();
   endtask

   // The sender pauses until every result is back, then resumes.
   task automatic test_sender_pause();
      int k;
      send_idle_pct = 30;
      stall_pct = 30;
      for (k = 0; k < 4; k++)
         send_sample(16'($urandom));
      wait_for_drain();
      for (k = 0; k < 4; k++)
         send_sample(16'($urandom));
      wait_for_drain();
   endtask

   // Random requests in runs around a level with noise of varying size, so the
   // filter settles and the integral winds up, plus some wide random samples.
   task automatic test_random_phase(input int n_items, input int send_idle, input int recv_stall);
      int                 sent, run_len, k, shift;
      logic signed [15:0] level, smp;
      send_idle_pct = send_idle;
      stall_pct = recv_stall;
      sent = 0;
      wait_for_drain();
      randomize_config();
      while (sent < n_items) begin
         if ($urandom_range(4, 0) == 0) begin
            wait_for_drain();
            randomize_config();
         end
         run_len = $urandom_range(30, 4);
         shift = $urandom_range(15, 0);
         case ($urandom_range(5, 0))
            0: level = 16'sh7FFF;
            1: level = 16'sh8000;
            2: level = target;
            default: level = 16'($urandom);
         endcase
         for (k = 0; k < run_len && sent < n_items; k++) begin
            if ($urandom_range(9, 0) == 0)
               smp = 16'($urandom);
            else
               smp = level + ($signed(16'($urandom)) >>> shift);
            send_sample(smp);
            sent = sent + 1;
         end
      end
      wait_for_drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = 16'sd0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_GAIN_PROP;
      csr_wdata = 16'sd0;
      errors = 0;
      requests_sent = 0;
      results_checked = 0;
      reg_writes = 0;
      integ_clamps_seen = 0;
      drive_clamps_seen = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_left = 0;
      gain_p = 16'sd0;
      gain_i = 16'sd0;
      gain_d = 16'sd0;
      target = 16'sd0;
      integ_lo = 16'sh8000;
      integ_hi = 16'sh7FFF;
      drive_lo = 16'sh8000;
      drive_hi = 16'sh7FFF;
      filt_q = 0;
      integ_q = 0;
      prev_err_q = 0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_field_extremes();
      test_exact_limits();
      test_inverted_limits();
      test_result_backpressure();
      test_sender_pause();
      test_random_phase(240, 0, 0);
      test_random_phase(240, 58, 0);
      test_random_phase(240, 0, 58);
      test_random_phase(240, 37, 37);

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_drives.size() != 0)
         report_mismatch("results still outstanding", pending_drives.size(), 0);

      $display("Sent %0d samples and checked %0d drive results across %0d register writes.",
               requests_sent, results_checked, reg_writes);
      $display("Integral limit hit %0d times, drive limit hit %0d times.",
               integ_clamps_seen, drive_clamps_seen);
      if (errors == 0) begin
         $display("pid_controller_filtered_input test passed");
      end else begin
         $display("pid_controller_filtered_input test failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/pidf_pkg.sv
rtl/pid_controller_filtered_input.sv
rtl/pidf_checker.sv
tb/tb_pid_controller_filtered_input.sv
